// ----- rtl/pfdr_pkg.sv -----
package pfdr_pkg;

   // default geometry of the frame
   localparam int DEFAULT_PAGES   = 8;
   localparam int DEFAULT_COLUMNS = 128;
   localparam int BYTE_W          = 8;

   // field widths of the channels
   localparam int OP_W    = 2;
   localparam int ROW_W   = 7;
   localparam int COLF_W  = 8;
   localparam int PAGEF_W = 3;
   localparam int POS_W   = 7;
   localparam int PGOUT_W = 3;
   localparam int CLOUT_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR_ALL    = 2'd0,
      OP_FILL_RECT    = 2'd1,
      OP_WRITE_BYTE   = 2'd2,
      OP_REFRESH_STEP = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // one operation beat
   typedef struct packed {
      op_type              operation;
      logic [ROW_W-1:0]    x_first;
      logic [COLF_W-1:0]   y_first;
      logic [ROW_W-1:0]    x_end;
      logic [COLF_W-1:0]   y_end;
      logic                pixel_value;
      logic [PAGEF_W-1:0]  page;
      logic [POS_W-1:0]    position;
      logic [BYTE_W-1:0]   byte_value;
   } req_type;

   // one refresh result beat
   typedef struct packed {
      logic                changed;
      logic [PGOUT_W-1:0]  page_out;
      logic [CLOUT_W-1:0]  column_out;
      logic [BYTE_W-1:0]   data_out;
      logic                scan_done;
   } rsp_type;

   // mirror bit order of a column byte
   function automatic logic [BYTE_W-1:0] bit_reverse(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] s;
      s = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
      s = ((s & 8'hCC) >> 2) | ((s & 8'h33) << 2);
      s = ((s & 8'hAA) >> 1) | ((s & 8'h55) << 1);
      return s;
   endfunction

endpackage

// ----- rtl/page_framebuffer_dirty_refresh.sv -----
// Page-organized monochrome frame store with dirty-byte refresh.
// Operation beats enter on req_* (valid/ready); refresh results leave on
// rsp_* (valid/ready). Only refresh_step produces a result beat.
// csr_write_enable/csr_write_data set the half-turn rotation (reset 1).
// One operation is worked on at a time, out of a frame memory and a shadow
// memory; fill_rect and refresh_step walk one entry per cycle through the
// read port with write-back in the following cycle:
//   write_byte   written as accepted, if page and position are in range
//   clear_all    fill sweep over every entry of both memories
//   fill_rect    one read-merge-write per touched byte (pages x columns),
//                an empty rectangle touches no byte
//   refresh_step scans from the pointer to the first dirty entry or the end
// After reset a clearing pass over every entry zeroes both memories;
// req_ready stays low during it.
// A refresh result sits in the output register; the next operation is
// accepted while it waits. A further refresh_step that finishes while the
// receiver still stalls holds its result until the output register frees.
module page_framebuffer_dirty_refresh
   import pfdr_pkg::*;
#(
   parameter int PAGES   = DEFAULT_PAGES,
   parameter int COLUMNS = DEFAULT_COLUMNS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [ROW_W-1:0]    req_x_first,
   input  logic [COLF_W-1:0]   req_y_first,
   input  logic [ROW_W-1:0]    req_x_end,
   input  logic [COLF_W-1:0]   req_y_end,
   input  logic                req_pixel_value,
   input  logic [PAGEF_W-1:0]  req_page,
   input  logic [POS_W-1:0]    req_position,
   input  logic [BYTE_W-1:0]   req_byte_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_changed,
   output logic [PGOUT_W-1:0]  rsp_page_out,
   output logic [CLOUT_W-1:0]  rsp_column_out,
   output logic [BYTE_W-1:0]   rsp_data_out,
   output logic                rsp_scan_done,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);

   localparam int ENTRIES = PAGES * COLUMNS;
   localparam int ADDR_W  = $clog2(ENTRIES);

   req_type            req;
   rsp_type            res;
   logic               res_valid, res_ready;
   logic               rotate_ff, rotate_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               fr_we, sh_we;
   logic [ADDR_W-1:0]  fr_waddr, fr_raddr, sh_waddr, sh_raddr;
   logic [BYTE_W-1:0]  fr_wdata, fr_rdata, sh_wdata, sh_rdata;

   // gather the operation beat
   assign req.operation   = op_type'(req_operation);
   assign req.x_first     = req_x_first;
   assign req.y_first     = req_y_first;
   assign req.x_end       = req_x_end;
   assign req.y_end       = req_y_end;
   assign req.pixel_value = req_pixel_value;
   assign req.page        = req_page;
   assign req.position    = req_position;
   assign req.byte_value  = req_byte_value;

   // rotation register
   assign rotate_in = csr_write_enable ? csr_write_data : rotate_ff;

   // output register
   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (res_valid && res_ready);
   assign rsp_in       = (res_valid && res_ready) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rotate_ff    <= rotate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_changed    = rsp_ff.changed;
   assign rsp_page_out   = rsp_ff.page_out;
   assign rsp_column_out = rsp_ff.column_out;
   assign rsp_data_out   = rsp_ff.data_out;
   assign rsp_scan_done  = rsp_ff.scan_done;

   // operation sequencer
   pfdr_engine #(
      .PAGES   (PAGES),
      .COLUMNS (COLUMNS),
      .ADDR_W  (ADDR_W)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .rotate    (rotate_ff),
      .req_valid (req_valid),
      .req       (req),
      .req_ready (req_ready),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .fr_we     (fr_we),
      .fr_waddr  (fr_waddr),
      .fr_wdata  (fr_wdata),
      .fr_raddr  (fr_raddr),
      .fr_rdata  (fr_rdata),
      .sh_we     (sh_we),
      .sh_waddr  (sh_waddr),
      .sh_wdata  (sh_wdata),
      .sh_raddr  (sh_raddr),
      .sh_rdata  (sh_rdata)
   );

   // frame memory
   pfdr_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (fr_wdata),
      .rd_addr (fr_raddr),
      .rd_data (fr_rdata)
   );

   // shadow memory
   pfdr_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_shadow_ram (
      .clock   (clock),
      .wr_en   (sh_we),
      .wr_addr (sh_waddr),
      .wr_data (sh_wdata),
      .rd_addr (sh_raddr),
      .rd_data (sh_rdata)
   );

endmodule

// ----- rtl/pfdr_ram.sv -----
module pfdr_ram
   import pfdr_pkg::*;
#(
   parameter int WIDTH  = BYTE_W,
   parameter int DEPTH  = DEFAULT_PAGES * DEFAULT_COLUMNS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pfdr_engine.sv -----
module pfdr_engine
   import pfdr_pkg::*;
#(
   parameter int PAGES   = DEFAULT_PAGES,
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ADDR_W  = $clog2(PAGES * COLUMNS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rotate,
   input  logic              req_valid,
   input  req_type           req,
   output logic              req_ready,
   output logic              res_valid,
   output rsp_type           res,
   input  logic              res_ready,
   output logic              fr_we,
   output logic [ADDR_W-1:0] fr_waddr,
   output logic [BYTE_W-1:0] fr_wdata,
   output logic [ADDR_W-1:0] fr_raddr,
   input  logic [BYTE_W-1:0] fr_rdata,
   output logic              sh_we,
   output logic [ADDR_W-1:0] sh_waddr,
   output logic [BYTE_W-1:0] sh_wdata,
   output logic [ADDR_W-1:0] sh_raddr,
   input  logic [BYTE_W-1:0] sh_rdata
);

   localparam int ROWS    = PAGES * 8;
   localparam int ENTRIES = PAGES * COLUMNS;
   localparam int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int COL_W   = $clog2(COLUMNS);
   localparam logic [PG_W-1:0]   PG_MAX    = PG_W'(PAGES - 1);
   localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(ENTRIES - 1);

   function automatic logic [ADDR_W-1:0] entry_addr(input logic [PG_W-1:0] pg,
                                                    input logic [COL_W-1:0] col);
      return ADDR_W'(32'(pg) * 32'(COLUMNS) + 32'(col));
   endfunction

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [BYTE_W-1:0]  clr_frame_ff, clr_frame_in;
   logic [BYTE_W-1:0]  clr_shadow_ff, clr_shadow_in;
   logic [PG_W-1:0]    ptr_pg_ff, ptr_pg_in;
   logic [COL_W-1:0]   ptr_col_ff, ptr_col_in;
   logic               issue_on_ff, issue_on_in;
   logic               st_valid_ff, st_valid_in;

   logic [PG_W-1:0]    cnt_pg_ff, cnt_pg_in;
   logic [COL_W-1:0]   cnt_col_ff, cnt_col_in;
   logic [ADDR_W-1:0]  st_addr_ff, st_addr_in;
   logic [BYTE_W-1:0]  st_mask_ff, st_mask_in;
   logic [PG_W-1:0]    st_pg_ff, st_pg_in;
   logic [COL_W-1:0]   st_col_ff, st_col_in;
   logic [ROW_W-1:0]   f_row_lo_ff, f_row_lo_in;
   logic [ROW_W-1:0]   f_row_last_ff, f_row_last_in;
   logic [COL_W-1:0]   f_col_lo_ff, f_col_lo_in;
   logic [COL_W-1:0]   f_col_last_ff, f_col_last_in;
   logic               f_val_ff, f_val_in;
   rsp_type            res_ff, res_in;

   // rectangle bounds from the incoming beat, clipped to the frame
   logic [ROW_W-1:0]   x_lo, x_hi;
   logic [COLF_W-1:0]  y_lo, y_hi;
   logic [ROW_W:0]     row_end;
   logic [COLF_W:0]    col_end;
   logic               fill_empty;

   assign x_lo = (req.x_first < req.x_end) ? req.x_first : req.x_end;
   assign x_hi = (req.x_first < req.x_end) ? req.x_end : req.x_first;
   assign y_lo = (req.y_first < req.y_end) ? req.y_first : req.y_end;
   assign y_hi = (req.y_first < req.y_end) ? req.y_end : req.y_first;
   assign row_end = ({1'b0, x_hi} < (ROW_W + 1)'(ROWS)) ? {1'b0, x_hi} : (ROW_W + 1)'(ROWS);
   assign col_end = ({1'b0, y_hi} < (COLF_W + 1)'(COLUMNS)) ? {1'b0, y_hi}
                                                              : (COLF_W + 1)'(COLUMNS);
   assign fill_empty = ({1'b0, x_lo} >= row_end) || ({1'b0, y_lo} >= col_end);

   // byte write address and data
   logic               wb_ok;
   logic [ADDR_W-1:0]  wb_addr;
   logic [BYTE_W-1:0]  wb_data;

   assign wb_ok = ({2'b00, req.page} < 5'(PAGES)) &&
                  ({1'b0, req.position} < 8'(COLUMNS - 2));
   assign wb_addr = rotate ?
      entry_addr(PG_MAX - PG_W'(req.page), COL_W'(COLUMNS - 2) - COL_W'(req.position)) :
      entry_addr(PG_W'(req.page), COL_W'(req.position) + COL_W'(1));
   assign wb_data = rotate ? bit_reverse(req.byte_value) : req.byte_value;

   // fill walk: bit mask of the current page and its mirrored place
   logic [PG_W-1:0]    pg_first, pg_last;
   logic [2:0]         lo_bit, hi_bit;
   logic [BYTE_W-1:0]  mask_log;
   logic [PG_W-1:0]    phys_pg;
   logic [COL_W-1:0]   phys_col;
   logic [ADDR_W-1:0]  fill_addr;
   logic [BYTE_W-1:0]  fill_mask;
   logic [BYTE_W-1:0]  fill_data;

   assign pg_first  = PG_W'(f_row_lo_ff >> 3);
   assign pg_last   = PG_W'(f_row_last_ff >> 3);
   assign lo_bit    = (cnt_pg_ff == pg_first) ? f_row_lo_ff[2:0] : 3'd0;
   assign hi_bit    = (cnt_pg_ff == pg_last) ? f_row_last_ff[2:0] : 3'd7;
   assign mask_log  = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
   assign phys_pg   = rotate ? PG_MAX - cnt_pg_ff : cnt_pg_ff;
   assign phys_col  = rotate ? COL_MAX - cnt_col_ff : cnt_col_ff;
   assign fill_addr = entry_addr(phys_pg, phys_col);
   assign fill_mask = rotate ? bit_reverse(mask_log) : mask_log;
   assign fill_data = f_val_ff ? (fr_rdata | st_mask_ff) : (fr_rdata & ~st_mask_ff);

   // scan walk
   logic [ADDR_W-1:0]  scan_addr;
   logic               cnt_last, st_last, diff;

   assign scan_addr = entry_addr(cnt_pg_ff, cnt_col_ff);
   assign cnt_last  = (cnt_pg_ff == PG_MAX) && (cnt_col_ff == COL_MAX);
   assign st_last   = (st_pg_ff == PG_MAX) && (st_col_ff == COL_MAX);
   assign diff      = fr_rdata != sh_rdata;

   // next state, memory ports and datapath
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_frame_in  = clr_frame_ff;
      clr_shadow_in = clr_shadow_ff;
      ptr_pg_in     = ptr_pg_ff;
      ptr_col_in    = ptr_col_ff;
      issue_on_in   = issue_on_ff;
      st_valid_in   = 1'b0;
      cnt_pg_in     = cnt_pg_ff;
      cnt_col_in    = cnt_col_ff;
      st_addr_in    = st_addr_ff;
      st_mask_in    = st_mask_ff;
      st_pg_in      = st_pg_ff;
      st_col_in     = st_col_ff;
      f_row_lo_in   = f_row_lo_ff;
      f_row_last_in = f_row_last_ff;
      f_col_lo_in   = f_col_lo_ff;
      f_col_last_in = f_col_last_ff;
      f_val_in      = f_val_ff;
      res_in        = res_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      fr_we         = 1'b0;
      fr_waddr      = st_addr_ff;
      fr_wdata      = fill_data;
      fr_raddr      = fill_addr;
      sh_we         = 1'b0;
      sh_waddr      = st_addr_ff;
      sh_wdata      = fr_rdata;
      sh_raddr      = scan_addr;

      unique case (state_ff)
         ST_CLEAR: begin
            fr_we    = 1'b1;
            fr_waddr = clr_addr_ff;
            fr_wdata = clr_frame_ff;
            sh_we    = 1'b1;
            sh_waddr = clr_addr_ff;
            sh_wdata = clr_shadow_ff;
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req.operation)
                  OP_CLEAR_ALL: begin
                     clr_addr_in   = '0;
                     clr_frame_in  = {BYTE_W{req.pixel_value}};
                     clr_shadow_in = {BYTE_W{~req.pixel_value}};
                     state_in      = ST_CLEAR;
                  end
                  OP_FILL_RECT: begin
                     f_row_lo_in   = x_lo;
                     f_row_last_in = ROW_W'(row_end - (ROW_W + 1)'(1));
                     f_col_lo_in   = COL_W'(y_lo);
                     f_col_last_in = COL_W'(col_end - (COLF_W + 1)'(1));
                     f_val_in      = req.pixel_value;
                     cnt_pg_in     = PG_W'(x_lo >> 3);
                     cnt_col_in    = COL_W'(y_lo);
                     issue_on_in   = 1'b1;
                     if (!fill_empty) begin
                        state_in = ST_FILL;
                     end
                  end
                  OP_WRITE_BYTE: begin
                     fr_we    = wb_ok;
                     fr_waddr = wb_addr;
                     fr_wdata = wb_data;
                  end
                  OP_REFRESH_STEP: begin
                     cnt_pg_in   = ptr_pg_ff;
                     cnt_col_in  = ptr_col_ff;
                     issue_on_in = 1'b1;
                     state_in    = ST_SCAN;
                  end
               endcase
            end
         end

         ST_FILL: begin
            // read one byte, merge the mask and write it back in the next cycle
            fr_raddr    = fill_addr;
            fr_we       = st_valid_ff;
            st_valid_in = issue_on_ff;
            st_addr_in  = fill_addr;
            st_mask_in  = fill_mask;
            if (issue_on_ff) begin
               if (cnt_col_ff == f_col_last_ff) begin
                  cnt_col_in = f_col_lo_ff;
                  if (cnt_pg_ff == pg_last) begin
                     issue_on_in = 1'b0;
                  end else begin
                     cnt_pg_in = cnt_pg_ff + PG_W'(1);
                  end
               end else begin
                  cnt_col_in = cnt_col_ff + COL_W'(1);
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // read frame and shadow, copy frame into shadow in the next cycle
            fr_raddr    = scan_addr;
            sh_raddr    = scan_addr;
            sh_we       = st_valid_ff;
            st_valid_in = issue_on_ff;
            st_addr_in  = scan_addr;
            st_pg_in    = cnt_pg_ff;
            st_col_in   = cnt_col_ff;
            if (issue_on_ff) begin
               if (cnt_last) begin
                  issue_on_in = 1'b0;
               end else if (cnt_col_ff == COL_MAX) begin
                  cnt_col_in = '0;
                  cnt_pg_in  = cnt_pg_ff + PG_W'(1);
               end else begin
                  cnt_col_in = cnt_col_ff + COL_W'(1);
               end
            end
            if (st_valid_ff && (diff || st_last)) begin
               res_in.changed    = diff;
               res_in.page_out   = diff ? PGOUT_W'(32'(st_pg_ff)) : '0;
               res_in.column_out = diff ? CLOUT_W'(32'(st_col_ff)) : '0;
               res_in.data_out   = diff ? fr_rdata : '0;
               res_in.scan_done  = st_last;
               if (st_last) begin
                  ptr_pg_in  = '0;
                  ptr_col_in = '0;
               end else if (st_col_ff == COL_MAX) begin
                  ptr_pg_in  = st_pg_ff + PG_W'(1);
                  ptr_col_in = '0;
               end else begin
                  ptr_pg_in  = st_pg_ff;
                  ptr_col_in = st_col_ff + COL_W'(1);
               end
               issue_on_in = 1'b0;
               st_valid_in = 1'b0;
               state_in    = ST_EMIT;
            end
         end

         ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

   // control state; reset starts a clearing pass over both stores
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         clr_frame_ff  <= '0;
         clr_shadow_ff <= '0;
         ptr_pg_ff     <= '0;
         ptr_col_ff    <= '0;
         issue_on_ff   <= 1'b0;
         st_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         clr_frame_ff  <= clr_frame_in;
         clr_shadow_ff <= clr_shadow_in;
         ptr_pg_ff     <= ptr_pg_in;
         ptr_col_ff    <= ptr_col_in;
         issue_on_ff   <= issue_on_in;
         st_valid_ff   <= st_valid_in;
      end
   end

   // walk counters and payload
   always_ff @(posedge clock) begin
      cnt_pg_ff     <= cnt_pg_in;
      cnt_col_ff    <= cnt_col_in;
      st_addr_ff    <= st_addr_in;
      st_mask_ff    <= st_mask_in;
      st_pg_ff      <= st_pg_in;
      st_col_ff     <= st_col_in;
      f_row_lo_ff   <= f_row_lo_in;
      f_row_last_ff <= f_row_last_in;
      f_col_lo_ff   <= f_col_lo_in;
      f_col_last_ff <= f_col_last_in;
      f_val_ff      <= f_val_in;
      res_ff        <= res_in;
   end

endmodule

// ----- verif/tb_page_framebuffer_dirty_refresh.sv -----
module tb_page_framebuffer_dirty_refresh;
   import pfdr_pkg::*;

   localparam int PAGES          = DEFAULT_PAGES;
   localparam int COLUMNS        = DEFAULT_COLUMNS;
   localparam int ENTRIES        = PAGES * COLUMNS;
   localparam int ROWS           = PAGES * 8;
   localparam int REQ_BITS       = $bits(req_type);
   // drain margin covers the longest single operation, a full sweep of the memories
   localparam int DRAIN_CYCLES   = ENTRIES + 100;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEMS_PER_PHASE = 100;

   // predicted frame, shadow and scan state plus the queue of refresh beats
   class frame_scoreboard;
      logic [BYTE_W-1:0] frame_mem [ENTRIES];
      logic [BYTE_W-1:0] shadow_mem [ENTRIES];
      int unsigned       scan_ptr;
      bit                rotate;
      rsp_type           refresh_queue [$];
      int                errors;
      int                refresh_count;

      function new();
         foreach (frame_mem[i]) begin
            frame_mem[i]  = '0;
            shadow_mem[i] = '0;
         end
         scan_ptr      = 0;
         rotate        = 1'b1;
         errors        = 0;
         refresh_count = 0;
      endfunction

      function void set_rotate(bit v);
         rotate = v;
      endfunction

      function int pending();
         return refresh_queue.size();
      endfunction

      function logic [BYTE_W-1:0] mirror_byte(logic [BYTE_W-1:0] v);
         logic [BYTE_W-1:0] m;
         for (int i = 0; i < BYTE_W; i++) m[i] = v[BYTE_W-1-i];
         return m;
      endfunction

      // set or clear pixels of the half-open rectangle, clipped to the frame
      function void apply_fill(req_type item);
         int x0, x1, y0, y1, pg, bt, col;
         x0 = (item.x_first < item.x_end) ? item.x_first : item.x_end;
         x1 = (item.x_first < item.x_end) ? item.x_end : item.x_first;
         y0 = (item.y_first < item.y_end) ? item.y_first : item.y_end;
         y1 = (item.y_first < item.y_end) ? item.y_end : item.y_first;
         for (int r = x0; r < x1 && r < ROWS; r++) begin
            for (int c = y0; c < y1 && c < COLUMNS; c++) begin
               if (rotate) begin
                  pg  = PAGES - 1 - r / 8;
                  bt  = 7 - r % 8;
                  col = COLUMNS - 1 - c;
               end else begin
                  pg  = r / 8;
                  bt  = r % 8;
                  col = c;
               end
               frame_mem[pg * COLUMNS + col][bt] = item.pixel_value;
            end
         end
      endfunction

      // column byte lands one column to the right; the top two positions drop
      function void apply_byte_write(req_type item);
         int idx;
         if (item.position >= COLUMNS - 2) return;
         if (rotate) begin
            idx = (PAGES - 1 - item.page) * COLUMNS + (COLUMNS - 2 - item.position);
            frame_mem[idx] = mirror_byte(item.byte_value);
         end else begin
            idx = item.page * COLUMNS + item.position + 1;
            frame_mem[idx] = item.byte_value;
         end
      endfunction

      // walk from the pointer, sync shadow, stop after the first dirty byte
      function rsp_type predict_refresh();
         rsp_type     r;
         int unsigned e;
         bit          found;
         r     = '0;
         e     = (scan_ptr < ENTRIES) ? scan_ptr : 0;
         found = 1'b0;
         while (e < ENTRIES && !found) begin
            if (frame_mem[e] != shadow_mem[e]) begin
               r.changed    = 1'b1;
               r.page_out   = PGOUT_W'(e / COLUMNS);
               r.column_out = CLOUT_W'(e % COLUMNS);
               r.data_out   = frame_mem[e];
               found        = 1'b1;
            end
            shadow_mem[e] = frame_mem[e];
            e++;
         end
         if (e >= ENTRIES) begin
            scan_ptr    = 0;
            r.scan_done = 1'b1;
         end else begin
            scan_ptr = e;
         end
         return r;
      endfunction

      function void note_op(req_type item);
         case (item.operation)
            OP_CLEAR_ALL: begin
               foreach (frame_mem[i]) begin
                  frame_mem[i]  = item.pixel_value ? 8'hFF : 8'h00;
                  shadow_mem[i] = item.pixel_value ? 8'h00 : 8'hFF;
               end
            end
            OP_FILL_RECT:  apply_fill(item);
            OP_WRITE_BYTE: apply_byte_write(item);
            default:       refresh_queue.push_back(predict_refresh());
         endcase
      endfunction

      task report(string msg);
         if (errors < 40) $display("mismatch: %s", msg);
         errors++;
      endtask

      task compare_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
         if (got !== want)
            report($sformatf("refresh beat %0d %s got %0h expected %0h",
                             refresh_count, name, got, want));
      endtask

      task check_refresh(rsp_type got);
         rsp_type want;
         if (refresh_queue.size() == 0) begin
            report($sformatf("refresh beat %0d arrived with none outstanding",
                             refresh_count));
         end else begin
            want = refresh_queue.pop_front();
            compare_field("changed",    BYTE_W'(got.changed),    BYTE_W'(want.changed));
            compare_field("page_out",   BYTE_W'(got.page_out),   BYTE_W'(want.page_out));
            compare_field("column_out", BYTE_W'(got.column_out), BYTE_W'(want.column_out));
            compare_field("data_out",   got.data_out,            want.data_out);
            compare_field("scan_done",  BYTE_W'(got.scan_done),  BYTE_W'(want.scan_done));
         end
         refresh_count++;
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation;
   logic [ROW_W-1:0]    req_x_first;
   logic [COLF_W-1:0]   req_y_first;
   logic [ROW_W-1:0]    req_x_end;
   logic [COLF_W-1:0]   req_y_end;
   logic                req_pixel_value;
   logic [PAGEF_W-1:0]  req_page;
   logic [POS_W-1:0]    req_position;
   logic [BYTE_W-1:0]   req_byte_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_changed;
   logic [PGOUT_W-1:0]  rsp_page_out;
   logic [CLOUT_W-1:0]  rsp_column_out;
   logic [BYTE_W-1:0]   rsp_data_out;
   logic                rsp_scan_done;
   logic                csr_write_enable;
   logic                csr_write_data;

   frame_scoreboard sb;
   bit              hold_off_pending = 1'b0;
   int              quiet_cycles = 0;
   req_type         seen_op;
   rsp_type         seen_rsp;

   page_framebuffer_dirty_refresh u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_x_first      (req_x_first),
      .req_y_first      (req_y_first),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_pixel_value  (req_pixel_value),
      .req_page         (req_page),
      .req_position     (req_position),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_changed      (rsp_changed),
      .rsp_page_out     (rsp_page_out),
      .rsp_column_out   (rsp_column_out),
      .rsp_data_out     (rsp_data_out),
      .rsp_scan_done    (rsp_scan_done),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   function automatic req_type make_op(op_type op, int xf, int yf, int xe, int ye,
                                       int pv, int pg, int pos, int bv);
      req_type item;
      item.operation   = op;
      item.x_first     = ROW_W'(xf);
      item.y_first     = COLF_W'(yf);
      item.x_end       = ROW_W'(xe);
      item.y_end       = COLF_W'(ye);
      item.pixel_value = 1'(pv);
      item.page        = PAGEF_W'(pg);
      item.position    = POS_W'(pos);
      item.byte_value  = BYTE_W'(bv);
      return item;
   endfunction

   // random content in every field, then shaped per operation
   function automatic req_type random_op();
      req_type                    item;
      logic [REQ_BITS-1:0]        raw;
      logic [ROW_W-1:0]           xt;
      logic [COLF_W-1:0]          yt;
      int                         p;
      raw  = REQ_BITS'({$urandom, $urandom});
      item = raw;
      p    = $urandom_range(0, 99);
      if (p < 4) begin
         item.operation = OP_CLEAR_ALL;
      end else if (p < 34) begin
         item.operation = OP_FILL_RECT;
         if ($urandom_range(0, 19) != 0) begin
            item.x_first = ROW_W'($urandom_range(0, ROWS - 1));
            item.x_end   = ROW_W'(item.x_first + $urandom_range(0, 9));
            item.y_first = COLF_W'($urandom_range(0, COLUMNS - 1));
            item.y_end   = COLF_W'(item.y_first + $urandom_range(0, 24));
            if ($urandom_range(0, 1) == 1) begin
               xt           = item.x_first;
               item.x_first = item.x_end;
               item.x_end   = xt;
               yt           = item.y_first;
               item.y_first = item.y_end;
               item.y_end   = yt;
            end
         end
      end else if (p < 62) begin
         item.operation = OP_WRITE_BYTE;
         if ($urandom_range(0, 9) != 0) item.position = POS_W'($urandom_range(0, COLUMNS - 3));
      end else begin
         item.operation = OP_REFRESH_STEP;
      end
      return item;
   endfunction

   // offer one beat and hold it until accepted
   task automatic send_op(input req_type item);
      @(negedge clock);
      req_valid       = 1'b1;
      req_operation   = item.operation;
      req_x_first     = item.x_first;
      req_y_first     = item.y_first;
      req_x_end       = item.x_end;
      req_y_end       = item.y_end;
      req_pixel_value = item.pixel_value;
      req_page        = item.page;
      req_position    = item.position;
      req_byte_value  = item.byte_value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // all refresh beats back and the block finished with its last operation
   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_rotation(input bit v);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         send_op(random_op());
         idle_sender(pick_gap());
      end
   endtask

   // receiver: random stalls, quiet stretches, and one long hold-off on request
   initial begin
      int stall_left;
      int quiet_left;
      int p;
      stall_left = 0;
      quiet_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left       = HOLD_OFF_CYCLES;
            quiet_left       = 0;
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (quiet_left > 0) begin
            rsp_ready = 1'b1;
            quiet_left--;
         end else begin
            p = $urandom_range(0, 99);
            if (p < 3) begin
               quiet_left = $urandom_range(50, 300);
               rsp_ready  = 1'b1;
            end else if (p < 15) begin
               stall_left = $urandom_range(0, 3);
               rsp_ready  = 1'b0;
            end else if (p < 17) begin
               stall_left = $urandom_range(30, 300);
               rsp_ready  = 1'b0;
            end else begin
               rsp_ready = 1'b1;
            end
         end
      end
   end

   // monitor: check refresh beats, record accepted operations and rotation writes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_rsp.changed    = rsp_changed;
            seen_rsp.page_out   = rsp_page_out;
            seen_rsp.column_out = rsp_column_out;
            seen_rsp.data_out   = rsp_data_out;
            seen_rsp.scan_done  = rsp_scan_done;
            sb.check_refresh(seen_rsp);
         end
         if (req_valid && req_ready) begin
            seen_op.operation   = op_type'(req_operation);
            seen_op.x_first     = req_x_first;
            seen_op.y_first     = req_y_first;
            seen_op.x_end       = req_x_end;
            seen_op.y_end       = req_y_end;
            seen_op.pixel_value = req_pixel_value;
            seen_op.page        = req_page;
            seen_op.position    = req_position;
            seen_op.byte_value  = req_byte_value;
            sb.note_op(seen_op);
         end
         if (csr_write_enable) sb.set_rotate(csr_write_data);
      end
      // watchdog on cycles without any beat
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = '0;
      req_x_first      = '0;
      req_y_first      = '0;
      req_x_end        = '0;
      req_y_end        = '0;
      req_pixel_value  = 1'b0;
      req_page         = '0;
      req_position     = '0;
      req_byte_value   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      write_rotation(1'b1);

      // directed: clean scan, last entry dirty, write_byte edges, clipping,
      // empty rectangles, a full-frame fill and both clear polarities
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_FILL_RECT, 0, 0, 1, 1, 1, 0, 0, 0));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_WRITE_BYTE, 0, 0, 0, 0, 0, 0, 0, 8'h01));
      send_op(make_op(OP_WRITE_BYTE, 0, 0, 0, 0, 0, 7, 125, 8'h80));
      send_op(make_op(OP_WRITE_BYTE, 0, 0, 0, 0, 0, 3, 126, 8'hA5));
      send_op(make_op(OP_WRITE_BYTE, 0, 0, 0, 0, 0, 3, 127, 8'h5A));
      send_op(make_op(OP_FILL_RECT, 127, 255, 60, 120, 1, 0, 0, 0));
      send_op(make_op(OP_FILL_RECT, 5, 0, 5, 128, 1, 0, 0, 0));
      send_op(make_op(OP_FILL_RECT, 0, 9, 64, 9, 1, 0, 0, 0));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_FILL_RECT, 0, 0, 64, 128, 0, 0, 0, 0));
      send_op(make_op(OP_WRITE_BYTE, 0, 0, 0, 0, 0, 7, 0, 8'hFF));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_CLEAR_ALL, 0, 0, 0, 0, 1, 0, 0, 0));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      send_op(make_op(OP_FILL_RECT, 8, 64, 16, 65, 1, 0, 0, 0));
      send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      wait_quiet();

      // unrotated
      write_rotation(1'b0);
      run_random(ITEMS_PER_PHASE);
      wait_quiet();

      // rotated, starting with the receiver held off so the block backs up
      write_rotation(1'b1);
      hold_off_pending = 1'b1;
      send_op(make_op(OP_CLEAR_ALL, 0, 0, 0, 0, $urandom_range(0, 1), 0, 0, 0));
      repeat (8) send_op(make_op(OP_REFRESH_STEP, 0, 0, 0, 0, 0, 0, 0, 0));
      run_random(ITEMS_PER_PHASE);
      wait_quiet();

      write_rotation(1'b0);
      run_random(ITEMS_PER_PHASE);
      wait_quiet();

      write_rotation(1'b1);
      run_random(ITEMS_PER_PHASE);
      wait_quiet();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pfdr_pkg.sv
rtl/pfdr_ram.sv
rtl/pfdr_engine.sv
rtl/page_framebuffer_dirty_refresh.sv
verif/tb_page_framebuffer_dirty_refresh.sv
